/* rtl/fcpf_pkg.sv */
// Shared constants, codes and types of the four-channel potentiometer filter.
package fcpf_pkg;

   localparam int CHANNELS       = 4;
   localparam int SLOT_COUNT     = 12;
   localparam int LAST_SLOT      = 11;
   localparam int SLOT_BITS      = 4;
   localparam int CHAN_BITS      = 2;
   localparam int COEF_BITS      = 16;
   localparam int MODE_BITS      = 2;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   typedef logic [MODE_BITS-1:0]      mode_type;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;
   typedef logic [COEF_BITS-1:0]      coef_type;
   typedef logic [SLOT_BITS-1:0]      slot_type;

   localparam mode_type MODE_MIDRANGE = 2'd0;
   localparam mode_type MODE_MEDIAN   = 2'd1;
   localparam mode_type MODE_LOWPASS  = 2'd2;

   localparam csr_index_type CSR_FILTER_MODE = 2'd0;
   localparam csr_index_type CSR_COEF_KEEP   = 2'd1;
   localparam csr_index_type CSR_COEF_NEW    = 2'd2;

   localparam mode_type MODE_RESET      = MODE_MEDIAN;
   localparam coef_type COEF_KEEP_RESET = 16'd60948;
   localparam coef_type COEF_NEW_RESET  = 16'd4588;

   typedef struct packed {
      logic                 fresh;
      logic [CHAN_BITS-1:0] next_channel;
   } item_ctrl_type;

endpackage

/* rtl/fcpf_req_if.sv */
// Sample channel: valid/ready handshake carrying one converter sample.
interface fcpf_req_if #(
   parameter int SAMPLE_BITS = 10
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

/* rtl/fcpf_rsp_if.sv */
// Result channel: valid/ready handshake carrying channel select and four positions.
interface fcpf_rsp_if #(
   parameter int SAMPLE_BITS = 10
);
   logic                            valid;
   logic                            ready;
   logic [fcpf_pkg::CHAN_BITS-1:0]  next_channel;
   logic                            fresh;
   logic [SAMPLE_BITS-1:0]          pos_zero;
   logic [SAMPLE_BITS-1:0]          pos_one;
   logic [SAMPLE_BITS-1:0]          pos_two;
   logic [SAMPLE_BITS-1:0]          pos_three;

   modport source (output valid, output next_channel, output fresh, output pos_zero,
                   output pos_one, output pos_two, output pos_three, input ready);
   modport sink   (input valid, input next_channel, input fresh, input pos_zero,
                   input pos_one, input pos_two, input pos_three, output ready);
endinterface

/* rtl/fcpf_three.sv */
// Midrange, median and truncated average of one channel's three samples.
module fcpf_three #(
   parameter int SAMPLE_BITS = 10
) (
   input  logic [SAMPLE_BITS-1:0] a,
   input  logic [SAMPLE_BITS-1:0] b,
   input  logic [SAMPLE_BITS-1:0] c,
   output logic [SAMPLE_BITS-1:0] midrange,
   output logic [SAMPLE_BITS-1:0] median,
   output logic [SAMPLE_BITS-1:0] avg
);
   localparam int SUM_BITS  = SAMPLE_BITS + 2;
   localparam int DIV_SHIFT = SUM_BITS + 1;
   localparam int MULT_BITS = DIV_SHIFT - 1;
   localparam int PROD_BITS = SUM_BITS + MULT_BITS;
   localparam logic [MULT_BITS-1:0] DIV_MULT =
      MULT_BITS'(((64'd1 << DIV_SHIFT) + 64'd2) / 64'd3);

   logic [SAMPLE_BITS-1:0] max_ab;
   logic [SAMPLE_BITS-1:0] min_ab;
   logic [SAMPLE_BITS-1:0] max_abc;
   logic [SAMPLE_BITS-1:0] min_abc;
   logic [SAMPLE_BITS:0]   span_sum;
   logic [SUM_BITS-1:0]    sum;
   logic [PROD_BITS-1:0]   prod;

   assign max_ab  = (a > b) ? a : b;
   assign min_ab  = (a < b) ? a : b;
   assign max_abc = (max_ab > c) ? max_ab : c;
   assign min_abc = (min_ab < c) ? min_ab : c;

   assign span_sum = (SAMPLE_BITS+1)'(max_abc) + (SAMPLE_BITS+1)'(min_abc);
   assign midrange = span_sum[SAMPLE_BITS:1];

   always_comb begin
      if (a >= b) begin
         if (b >= c) begin
            median = b;
         end else begin
            median = (a >= c) ? c : a;
         end
      end else begin
         if (a >= c) begin
            median = a;
         end else begin
            median = (b >= c) ? c : b;
         end
      end
   end

   // divide by three through the reciprocal
   assign sum  = SUM_BITS'(a) + SUM_BITS'(b) + SUM_BITS'(c);
   assign prod = PROD_BITS'(sum) * PROD_BITS'(DIV_MULT);
   assign avg  = prod[DIV_SHIFT +: SAMPLE_BITS];
endmodule

/* rtl/fcpf_lowpass.sv */
// One first-order low-pass step on a fixed-point state, truncated and saturated.
module fcpf_lowpass #(
   parameter int SAMPLE_BITS   = 10,
   parameter int FRACTION_BITS = 16
) (
   input  fcpf_pkg::coef_type                   coef_keep,
   input  fcpf_pkg::coef_type                   coef_new,
   input  logic [SAMPLE_BITS+FRACTION_BITS-1:0] state,
   input  logic [SAMPLE_BITS-1:0]               avg,
   output logic [SAMPLE_BITS+FRACTION_BITS-1:0] next_state
);
   localparam int STATE_BITS = SAMPLE_BITS + FRACTION_BITS;
   localparam int KEEP_BITS  = fcpf_pkg::COEF_BITS + STATE_BITS;
   localparam int NEW_BITS   = fcpf_pkg::COEF_BITS + SAMPLE_BITS;
   localparam int ACC_BITS   = KEEP_BITS + 1;

   logic [KEEP_BITS-1:0] keep_prod;
   logic [NEW_BITS-1:0]  new_prod;
   logic [ACC_BITS-1:0]  acc;
   logic [STATE_BITS:0]  scaled;

   assign keep_prod = KEEP_BITS'(coef_keep) * KEEP_BITS'(state);
   assign new_prod  = NEW_BITS'(coef_new) * NEW_BITS'(avg);
   assign acc       = ACC_BITS'(keep_prod) + (ACC_BITS'(new_prod) << FRACTION_BITS);
   assign scaled    = acc[ACC_BITS-1:fcpf_pkg::COEF_BITS];

   assign next_state = scaled[STATE_BITS] ? {STATE_BITS{1'b1}} : scaled[STATE_BITS-1:0];
endmodule

/* rtl/four_channel_pot_filter.sv */
// Four-channel potentiometer filter: sample store, round update and result register.
//
//   channel   direction   payload                                          handshake
//   req_chan  in          sample                                           valid/ready
//   rsp_chan  out         next_channel, fresh, pos_zero .. pos_three       valid/ready
//   csr_*     in          csr_index, csr_wr_data                           csr_wr_en
//
// One item per cycle while the result is not stalled. The stage register takes an
// item when it is accepted; the result register, which offers it, takes it from there
// when it is empty or being read (three-sample reduction before the stage register,
// low-pass multiply before the result register). Synchronous reset clears slot count,
// positions, low-pass state and both valid flags. A stalled result holds its register;
// the stage register still takes one more item behind it.
module four_channel_pot_filter #(
   parameter int SAMPLE_BITS   = 10,
   parameter int FRACTION_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   fcpf_req_if.sink                            req_chan,
   fcpf_rsp_if.source                          rsp_chan,
   input  logic                                csr_wr_en,
   input  fcpf_pkg::csr_index_type             csr_index,
   input  logic [fcpf_pkg::CSR_DATA_BITS-1:0]  csr_wr_data
);
   localparam int STATE_BITS = SAMPLE_BITS + FRACTION_BITS;
   localparam int CHANNELS   = fcpf_pkg::CHANNELS;
   localparam int SLOT_COUNT = fcpf_pkg::SLOT_COUNT;

   fcpf_pkg::mode_type mode_ff, mode_in;
   fcpf_pkg::coef_type coef_keep_ff, coef_keep_in;
   fcpf_pkg::coef_type coef_new_ff, coef_new_in;

   fcpf_pkg::slot_type slot_ff, slot_in;
   logic [SLOT_COUNT-1:0][SAMPLE_BITS-1:0] store_ff, store_in;
   logic [SLOT_COUNT-1:0][SAMPLE_BITS-1:0] entry;

   logic                                  s1_valid_ff, s1_valid_in;
   fcpf_pkg::item_ctrl_type               s1_ctrl_ff, s1_ctrl_in;
   logic [CHANNELS-1:0][SAMPLE_BITS-1:0]  s1_val_ff, s1_val_in;
   logic [CHANNELS-1:0][SAMPLE_BITS-1:0]  s1_avg_ff, s1_avg_in;

   logic                                  rsp_valid_ff, rsp_valid_in;
   fcpf_pkg::item_ctrl_type               rsp_ctrl_ff, rsp_ctrl_in;
   logic [CHANNELS-1:0][SAMPLE_BITS-1:0]  positions_ff, positions_in;
   logic [CHANNELS-1:0][STATE_BITS-1:0]   lowpass_ff, lowpass_in;

   logic [CHANNELS-1:0][SAMPLE_BITS-1:0]  mid_val;
   logic [CHANNELS-1:0][SAMPLE_BITS-1:0]  med_val;
   logic [CHANNELS-1:0][SAMPLE_BITS-1:0]  avg_val;
   logic [CHANNELS-1:0][STATE_BITS-1:0]   lp_next;

   logic accept;
   logic s2_load;
   logic s1_free;
   logic last_slot;

   assign s2_load        = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign s1_free        = !s1_valid_ff || s2_load;
   assign req_chan.ready = s1_free;
   assign accept         = req_chan.valid && s1_free;
   assign last_slot      = !(slot_ff < fcpf_pkg::SLOT_BITS'(fcpf_pkg::LAST_SLOT));

   // configuration
   always_comb begin
      mode_in      = mode_ff;
      coef_keep_in = coef_keep_ff;
      coef_new_in  = coef_new_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            fcpf_pkg::CSR_FILTER_MODE: mode_in      = csr_wr_data[fcpf_pkg::MODE_BITS-1:0];
            fcpf_pkg::CSR_COEF_KEEP:   coef_keep_in = csr_wr_data[fcpf_pkg::COEF_BITS-1:0];
            fcpf_pkg::CSR_COEF_NEW:    coef_new_in  = csr_wr_data[fcpf_pkg::COEF_BITS-1:0];
            default: ;
         endcase
      end
   end

   // sample store with bypass of the incoming item
   always_comb begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         entry[i] = (slot_ff == fcpf_pkg::SLOT_BITS'(i)) ? req_chan.sample : store_ff[i];
      end
   end

   always_comb begin
      store_in = store_ff;
      slot_in  = slot_ff;
      if (accept) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            if (slot_ff == fcpf_pkg::SLOT_BITS'(i)) begin
               store_in[i] = req_chan.sample;
            end
         end
         slot_in = last_slot ? '0 : slot_ff + 1'b1;
      end
   end

   for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_chan
      fcpf_three #(
         .SAMPLE_BITS (SAMPLE_BITS)
      ) u_three (
         .a        (entry[ch]),
         .b        (entry[ch + CHANNELS]),
         .c        (entry[ch + 2 * CHANNELS]),
         .midrange (mid_val[ch]),
         .median   (med_val[ch]),
         .avg      (avg_val[ch])
      );

      fcpf_lowpass #(
         .SAMPLE_BITS   (SAMPLE_BITS),
         .FRACTION_BITS (FRACTION_BITS)
      ) u_lowpass (
         .coef_keep  (coef_keep_ff),
         .coef_new   (coef_new_ff),
         .state      (lowpass_ff[ch]),
         .avg        (s1_avg_ff[ch]),
         .next_state (lp_next[ch])
      );
   end

   // stage one
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_ctrl_in  = s1_ctrl_ff;
      s1_val_in   = s1_val_ff;
      s1_avg_in   = s1_avg_ff;
      if (accept) begin
         s1_valid_in             = 1'b1;
         s1_ctrl_in.fresh        = last_slot;
         s1_ctrl_in.next_channel = slot_in[fcpf_pkg::CHAN_BITS-1:0];
         for (int ch = 0; ch < CHANNELS; ch++) begin
            s1_val_in[ch] = (mode_ff == fcpf_pkg::MODE_MIDRANGE) ? mid_val[ch] : med_val[ch];
         end
         s1_avg_in = avg_val;
      end else if (s2_load) begin
         s1_valid_in = 1'b0;
      end
   end

   // stage two: position update and result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_ctrl_in  = rsp_ctrl_ff;
      positions_in = positions_ff;
      lowpass_in   = lowpass_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (s2_load) begin
         rsp_valid_in = 1'b1;
         rsp_ctrl_in  = s1_ctrl_ff;
         if (s1_ctrl_ff.fresh) begin
            unique case (mode_ff)
               fcpf_pkg::MODE_MIDRANGE,
               fcpf_pkg::MODE_MEDIAN: begin
                  positions_in = s1_val_ff;
               end
               fcpf_pkg::MODE_LOWPASS: begin
                  lowpass_in = lp_next;
                  for (int ch = 0; ch < CHANNELS; ch++) begin
                     positions_in[ch] = lp_next[ch][STATE_BITS-1 -: SAMPLE_BITS];
                  end
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= fcpf_pkg::MODE_RESET;
         coef_keep_ff <= fcpf_pkg::COEF_KEEP_RESET;
         coef_new_ff  <= fcpf_pkg::COEF_NEW_RESET;
         slot_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         positions_ff <= '0;
         lowpass_ff   <= '0;
      end else begin
         mode_ff      <= mode_in;
         coef_keep_ff <= coef_keep_in;
         coef_new_ff  <= coef_new_in;
         slot_ff      <= slot_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         positions_ff <= positions_in;
         lowpass_ff   <= lowpass_in;
      end
   end

   always_ff @(posedge clock) begin
      store_ff    <= store_in;
      s1_ctrl_ff  <= s1_ctrl_in;
      s1_val_ff   <= s1_val_in;
      s1_avg_ff   <= s1_avg_in;
      rsp_ctrl_ff <= rsp_ctrl_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.next_channel = rsp_ctrl_ff.next_channel;
   assign rsp_chan.fresh        = rsp_ctrl_ff.fresh;
   assign rsp_chan.pos_zero     = positions_ff[0];
   assign rsp_chan.pos_one      = positions_ff[1];
   assign rsp_chan.pos_two      = positions_ff[2];
   assign rsp_chan.pos_three    = positions_ff[3];

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= fcpf_pkg::SLOT_BITS'(fcpf_pkg::LAST_SLOT))
      else $error("slot index beyond last slot");

   a_fresh_wraps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ctrl_ff.fresh |-> rsp_ctrl_ff.next_channel == '0)
      else $error("fresh item does not select channel zero");

   a_lowpass_hold: assert property (@(posedge clock) disable iff (reset)
      !(s2_load && s1_ctrl_ff.fresh) |=> $stable(lowpass_ff) && $stable(positions_ff))
      else $error("filter state changed outside a round update");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |-> !s2_load)
      else $error("result register overwritten while stalled");
endmodule

/* tb/fcpf_position_checker.sv */
// Position checker: mirrors the filter's sample store and round update, compares every result.
`timescale 1ns / 100ps
module fcpf_position_checker #(
   parameter int SAMPLE_BITS   = 10,
   parameter int FRACTION_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [SAMPLE_BITS-1:0]              req_sample,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [fcpf_pkg::CHAN_BITS-1:0]      rsp_next_channel,
   input  logic                                rsp_fresh,
   input  logic [SAMPLE_BITS-1:0]              rsp_pos_zero,
   input  logic [SAMPLE_BITS-1:0]              rsp_pos_one,
   input  logic [SAMPLE_BITS-1:0]              rsp_pos_two,
   input  logic [SAMPLE_BITS-1:0]              rsp_pos_three,
   input  logic                                csr_wr_en,
   input  fcpf_pkg::csr_index_type             csr_index,
   input  logic [fcpf_pkg::CSR_DATA_BITS-1:0]  csr_wr_data,
   output int                                  fail_count,
   output int                                  pending_count,
   output int                                  checked_count,
   output int                                  round_count
);

   localparam int STATE_BITS = SAMPLE_BITS + FRACTION_BITS;
   localparam logic [STATE_BITS-1:0] STATE_MAX = '1;

   typedef struct packed {
      logic [fcpf_pkg::CHAN_BITS-1:0] next_channel;
      logic                           fresh;
      logic [SAMPLE_BITS-1:0]         pos_zero;
      logic [SAMPLE_BITS-1:0]         pos_one;
      logic [SAMPLE_BITS-1:0]         pos_two;
      logic [SAMPLE_BITS-1:0]         pos_three;
   } position_item_type;

   logic [SAMPLE_BITS-1:0] store_q    [fcpf_pkg::SLOT_COUNT];
   fcpf_pkg::slot_type     slot_q;
   logic [STATE_BITS-1:0]  lowpass_q  [fcpf_pkg::CHANNELS];
   logic [SAMPLE_BITS-1:0] position_q [fcpf_pkg::CHANNELS];
   fcpf_pkg::mode_type     mode_q;
   fcpf_pkg::coef_type     keep_q;
   fcpf_pkg::coef_type     new_q;

   position_item_type expected_positions [$];
   position_item_type observed;
   int                errors  = 0;
   int                rounds  = 0;
   int                checked = 0;
   int                i;

   task automatic advance_filter(input logic [SAMPLE_BITS-1:0] sample);
      logic [SAMPLE_BITS-1:0] a, b, c, hi, lo;
      logic [SAMPLE_BITS:0]   span;
      logic [SAMPLE_BITS+1:0] sum;
      logic [SAMPLE_BITS+1:0] mid;
      logic [SAMPLE_BITS+1:0] avg;
      logic [63:0]            acc;
      logic [63:0]            next;
      logic                   fresh;
      int                     ch;
      position_item_type      item;
      fresh = 1'b0;
      if (slot_q < fcpf_pkg::SLOT_COUNT) store_q[slot_q] = sample;
      if (slot_q < fcpf_pkg::LAST_SLOT) begin
         slot_q = slot_q + 1'b1;
      end else begin
         slot_q = '0;
         fresh  = 1'b1;
         rounds++;
         for (ch = 0; ch < fcpf_pkg::CHANNELS; ch++) begin
            a    = store_q[ch];
            b    = store_q[ch + 4];
            c    = store_q[ch + 8];
            hi   = (a > b) ? a : b;
            hi   = (hi > c) ? hi : c;
            lo   = (a < b) ? a : b;
            lo   = (lo < c) ? lo : c;
            span = hi + lo;
            sum  = a + b + c;
            mid  = sum - hi - lo;
            case (mode_q)
               fcpf_pkg::MODE_MIDRANGE: position_q[ch] = span[SAMPLE_BITS:1];
               fcpf_pkg::MODE_MEDIAN:   position_q[ch] = mid[SAMPLE_BITS-1:0];
               fcpf_pkg::MODE_LOWPASS: begin
                  avg  = sum / 3'd3;
                  acc  = keep_q * lowpass_q[ch] + ((new_q * avg) << FRACTION_BITS);
                  next = acc >> fcpf_pkg::COEF_BITS;
                  if (next > STATE_MAX) next = STATE_MAX;
                  lowpass_q[ch]  = next[STATE_BITS-1:0];
                  position_q[ch] = next[STATE_BITS-1:FRACTION_BITS];
               end
               default: ;
            endcase
         end
      end
      item.next_channel = slot_q[fcpf_pkg::CHAN_BITS-1:0];
      item.fresh        = fresh;
      item.pos_zero     = position_q[0];
      item.pos_one      = position_q[1];
      item.pos_two      = position_q[2];
      item.pos_three    = position_q[3];
      expected_positions.push_back(item);
   endtask

   task automatic check_field(input string name, input int unsigned exp, input int unsigned act);
      if (exp != act) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp, act);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (i = 0; i < fcpf_pkg::SLOT_COUNT; i++) store_q[i] = '0;
         for (i = 0; i < fcpf_pkg::CHANNELS; i++) begin
            lowpass_q[i]  = '0;
            position_q[i] = '0;
         end
         slot_q = '0;
         mode_q = fcpf_pkg::MODE_RESET;
         keep_q = fcpf_pkg::COEF_KEEP_RESET;
         new_q  = fcpf_pkg::COEF_NEW_RESET;
         expected_positions.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               fcpf_pkg::CSR_FILTER_MODE: mode_q = csr_wr_data[fcpf_pkg::MODE_BITS-1:0];
               fcpf_pkg::CSR_COEF_KEEP:   keep_q = csr_wr_data[fcpf_pkg::COEF_BITS-1:0];
               fcpf_pkg::CSR_COEF_NEW:    new_q  = csr_wr_data[fcpf_pkg::COEF_BITS-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_positions.size() == 0) begin
               $error("result item with no expected item waiting");
               errors++;
            end else begin
               observed = expected_positions.pop_front();
               check_field("next_channel", observed.next_channel, rsp_next_channel);
               check_field("fresh", observed.fresh, rsp_fresh);
               check_field("pos_zero", observed.pos_zero, rsp_pos_zero);
               check_field("pos_one", observed.pos_one, rsp_pos_one);
               check_field("pos_two", observed.pos_two, rsp_pos_two);
               check_field("pos_three", observed.pos_three, rsp_pos_three);
               checked++;
            end
         end
         if (req_valid && req_ready) advance_filter(req_sample);
      end
      fail_count    <= errors;
      pending_count <= expected_positions.size();
      checked_count <= checked;
      round_count   <= rounds;
   end

endmodule

/* tb/tb_top.sv */
// Testbench top: clock, reset, sample and register stimulus, result back-pressure and verdict.
`timescale 1ns / 100ps
module tb_top;

   localparam int SAMPLE_BITS    = 10;
   localparam int FRACTION_BITS  = 16;
   localparam int HOLDOFF_CYCLES = 40;
   localparam int IDLE_LIMIT     = 1000;
   localparam int DRAIN_CYCLES   = 4;
   localparam fcpf_pkg::mode_type      MODE_UNDEFINED = 2'd3;
   localparam fcpf_pkg::csr_index_type CSR_UNUSED     = 2'd3;
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

   logic                               clock = 1'b0;
   logic                               reset;
   logic                               csr_wr_en;
   fcpf_pkg::csr_index_type            csr_index;
   logic [fcpf_pkg::CSR_DATA_BITS-1:0] csr_wr_data;

   int idle_pct      = 0;
   int stall_pct     = 0;
   int hold_left     = 0;
   bit holdoff_start = 1'b0;
   int sent          = 0;
   int phases        = 0;
   int quiet         = 0;
   int pattern;
   int fail_count, pending_count, checked_count, round_count;

   logic [SAMPLE_BITS-1:0] directed [fcpf_pkg::SLOT_COUNT] = '{
      10'd0,    10'd1023, 10'd1,   10'h2AA,
      10'd1023, 10'd1023, 10'd3,   10'h155,
      10'd512,  10'd0,    10'd2,   10'h3FF
   };

   fcpf_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_if ();
   fcpf_rsp_if #(.SAMPLE_BITS(SAMPLE_BITS)) rsp_if ();

   four_channel_pot_filter #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   fcpf_position_checker #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) position_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_if.valid),
      .req_ready        (req_if.ready),
      .req_sample       (req_if.sample),
      .rsp_valid        (rsp_if.valid),
      .rsp_ready        (rsp_if.ready),
      .rsp_next_channel (rsp_if.next_channel),
      .rsp_fresh        (rsp_if.fresh),
      .rsp_pos_zero     (rsp_if.pos_zero),
      .rsp_pos_one      (rsp_if.pos_one),
      .rsp_pos_two      (rsp_if.pos_two),
      .rsp_pos_three    (rsp_if.pos_three),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data),
      .fail_count       (fail_count),
      .pending_count    (pending_count),
      .checked_count    (checked_count),
      .round_count      (round_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(7))
         0:       return '0;
         1:       return SAMPLE_MAX;
         default: return SAMPLE_BITS'($urandom_range(SAMPLE_MAX));
      endcase
   endfunction

   function automatic fcpf_pkg::coef_type any_coef();
      return fcpf_pkg::coef_type'($urandom);
   endfunction

   function automatic fcpf_pkg::mode_type any_mode();
      return fcpf_pkg::mode_type'($urandom_range(3));
   endfunction

   task automatic send_sample(input logic [SAMPLE_BITS-1:0] value);
      while ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.sample <= value;
      do @(posedge clock); while (!req_if.ready);
      sent++;
   endtask

   task automatic drain_block();
      req_if.valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_registers(input fcpf_pkg::mode_type mode, input fcpf_pkg::coef_type keep,
                                  input fcpf_pkg::coef_type fresh_weight);
      logic [fcpf_pkg::CSR_DATA_BITS-1:0] mode_word;
      mode_word = fcpf_pkg::CSR_DATA_BITS'($urandom);
      mode_word[fcpf_pkg::MODE_BITS-1:0] = mode;
      csr_wr_en   <= 1'b1;
      csr_index   <= fcpf_pkg::CSR_FILTER_MODE;
      csr_wr_data <= mode_word;
      @(posedge clock);
      csr_index   <= fcpf_pkg::CSR_COEF_KEEP;
      csr_wr_data <= keep;
      @(posedge clock);
      csr_index   <= fcpf_pkg::CSR_COEF_NEW;
      csr_wr_data <= fresh_weight;
      @(posedge clock);
      csr_index   <= CSR_UNUSED;
      csr_wr_data <= fcpf_pkg::CSR_DATA_BITS'($urandom);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic run_phase(input fcpf_pkg::mode_type mode, input fcpf_pkg::coef_type keep,
                            input fcpf_pkg::coef_type fresh_weight, input int idle,
                            input int stall, input int count, input bit holdoff);
      drain_block();
      write_registers(mode, keep, fresh_weight);
      idle_pct  = idle;
      stall_pct = stall;
      if (holdoff) holdoff_start = 1'b1;
      repeat (count) send_sample(pick_sample());
      phases++;
   endtask

   // receiver: random stall, or a long hold-off on request
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holdoff_start) begin
            holdoff_start = 1'b0;
            hold_left     = HOLDOFF_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   initial begin
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
         else quiet++;
      end
      $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      reset         <= 1'b1;
      req_if.valid  <= 1'b0;
      req_if.sample <= '0;
      csr_wr_en     <= 1'b0;
      csr_index     <= fcpf_pkg::CSR_FILTER_MODE;
      csr_wr_data   <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[k]) send_sample(directed[k]);
      drain_block();
      write_registers(fcpf_pkg::MODE_MIDRANGE, fcpf_pkg::COEF_KEEP_RESET,
                      fcpf_pkg::COEF_NEW_RESET);
      foreach (directed[k]) send_sample(directed[k]);

      run_phase(fcpf_pkg::MODE_LOWPASS, fcpf_pkg::COEF_KEEP_RESET, fcpf_pkg::COEF_NEW_RESET,
                0, 0, 120, 1'b1);
      run_phase(MODE_UNDEFINED, any_coef(), any_coef(), 68, 0, 60, 1'b0);
      run_phase(fcpf_pkg::MODE_MIDRANGE, 16'h0000, 16'hFFFF, 0, 68, 150, 1'b1);
      run_phase(fcpf_pkg::MODE_LOWPASS, 16'hFFFF, 16'hFFFF, 7, 7, 200, 1'b0);
      run_phase(fcpf_pkg::MODE_MEDIAN, any_coef(), any_coef(), 68, 0, 100, 1'b0);
      run_phase(fcpf_pkg::MODE_LOWPASS, 16'h0000, 16'h0000, 0, 68, 100, 1'b0);
      run_phase(fcpf_pkg::MODE_LOWPASS, any_coef(), any_coef(), 68, 0, 200, 1'b0);
      repeat (4) begin
         pattern = $urandom_range(3);
         case (pattern)
            0:       run_phase(any_mode(), any_coef(), any_coef(), 0, 0, 120, 1'b0);
            1:       run_phase(any_mode(), any_coef(), any_coef(), 68, 0, 120, 1'b0);
            2:       run_phase(any_mode(), any_coef(), any_coef(), 0, 68, 120, 1'b0);
            default: run_phase(any_mode(), any_coef(), any_coef(), 7, 7, 120, 1'b0);
         endcase
      end
      drain_block();

      $display("Sent %0d samples in %0d register settings; %0d rounds, %0d results compared.",
               sent, phases + 2, round_count, checked_count);
      $display("Midrange, median, low-pass at coefficient extremes and saturation, undefined mode,"
               , " idle/stall mixes and a long result hold-off.");
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
